FILE: hw/rtl/token_bucket_table_assert.svh
// Assertion macros for the token bucket table.
// No dependencies; included by files that carry concurrent checks.
`ifndef TOKEN_BUCKET_TABLE_ASSERT_SVH
`define TOKEN_BUCKET_TABLE_ASSERT_SVH

// Implication in the same cycle, checked on every rising clock edge out of reset.
`define TBT_ASSERT_NOW(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("token_bucket_table check failed");

// Implication into the following cycle.
`define TBT_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("token_bucket_table check failed");

`endif

FILE: hw/rtl/tbt_pkg.sv
// Shared types for the token bucket table: command and status codes, bucket entry.
// No dependencies.
package tbt_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_CREATE  = 2'd1,
      CMD_FETCH   = 2'd2,
      CMD_DESTROY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ARG   = 2'd1,
      ST_NO_BUCKET = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] tokens;
      logic [15:0] rate;
      logic [15:0] limit;
      logic [31:0] stamp;
   } bucket_type;

endpackage

FILE: hw/rtl/tbt_alloc.sv
// Lowest-free-slot finder over the bucket valid bits.
// No package dependencies.
module tbt_alloc #(
   parameter int NUM_BUCKETS = 16,
   parameter int IDX_W       = 4
) (
   input  logic [NUM_BUCKETS-1:0] used,
   output logic                   any_free,
   output logic [IDX_W-1:0]       free_idx
);

   always_comb begin
      free_idx = '0;
      // scan downward so the lowest free slot wins
      for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign any_free = ~&used;

endmodule

FILE: hw/rtl/tbt_refill.sv
// Bucket refill and grant: elapsed time times rate, saturated at capacity, then take.
// Depends on tbt_pkg.
module tbt_refill
   import tbt_pkg::*;
(
   input  bucket_type  entry,
   input  logic [31:0] now,
   input  logic [15:0] wanted,
   output bucket_type  entry_out,
   output logic [15:0] grant
);

   logic [31:0] elapsed;
   logic [47:0] add_full;
   logic [15:0] room;
   logic [15:0] add_sat;
   logic [15:0] filled;

   assign elapsed  = now - entry.stamp;
   assign add_full = 48'(elapsed) * 48'(entry.rate);
   assign room     = (entry.limit > entry.tokens) ? (entry.limit - entry.tokens) : 16'd0;
   assign add_sat  = (add_full > {32'd0, room}) ? room : add_full[15:0];
   assign filled   = entry.tokens + add_sat;
   assign grant    = (wanted < filled) ? wanted : filled;

   // zero elapsed adds nothing and now equals the old stamp, so restamp always
   always_comb begin
      entry_out        = entry;
      entry_out.tokens = filled - grant;
      entry_out.stamp  = now;
   end

endmodule

FILE: hw/rtl/token_bucket_table.sv
// Token bucket table top level: request register, bucket memory, result register.
// Depends on tbt_pkg, tbt_alloc, tbt_refill and token_bucket_table_assert.svh.
//
//   channel | ports                                             | handshake
//   --------+---------------------------------------------------+------------------------
//   request | req_cmd req_slot req_rate req_capacity req_wanted | start & !busy
//   result  | rsp_status rsp_value                              | rsp_valid, one cycle
//
// One item per cycle. An item taken at an edge is held in the request register while the
// bucket memory read is registered, then passes the refill/allocate logic into the result
// register, which drives the rsp_ ports.
// busy stays low; the receiver cannot stall, so nothing backs up.
// reset clears the valid bits, the tick counter and the pipeline valids; bucket entries
// are not cleared, they are written on create before any read.
`include "token_bucket_table_assert.svh"

module token_bucket_table
   import tbt_pkg::*;
#(
   parameter int NUM_BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_rate,
   input  logic [15:0] req_capacity,
   input  logic [15:0] req_wanted,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_value
);

   localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   // request register
   logic        req_valid_ff;
   cmd_type     req_cmd_ff;
   logic [3:0]  req_slot_ff;
   logic [15:0] req_rate_ff;
   logic [15:0] req_capacity_ff;
   logic [15:0] req_wanted_ff;

   // bucket memory, registered read, plus a one-entry bypass of last cycle's write
   bucket_type  bucket_mem [NUM_BUCKETS];
   bucket_type  bucket_rd_ff;
   logic        byp_valid_ff;
   logic [IDX_W-1:0] byp_addr_ff;
   bucket_type  byp_data_ff;

   // table state
   logic [NUM_BUCKETS-1:0] used_ff, used_in;
   logic [31:0]            now_ff, now_in;

   // result register
   logic        rsp_valid_ff;
   status_type  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_value_ff, rsp_value_in;

   // stage logic
   logic             accept;
   logic [IDX_W-1:0] slot_idx;
   logic             slot_ok;
   bucket_type       entry_cur;
   bucket_type       entry_fetched;
   logic [15:0]      grant;
   logic             any_free;
   logic [IDX_W-1:0] free_idx;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   bucket_type       wr_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_cmd_ff      <= cmd_type'(req_cmd);
         req_slot_ff     <= req_slot;
         req_rate_ff     <= req_rate;
         req_capacity_ff <= req_capacity;
         req_wanted_ff   <= req_wanted;
      end
   end

   // memory: read by the incoming slot, written by the item in the compute stage
   always_ff @(posedge clock) begin
      bucket_rd_ff <= bucket_mem[IDX_W'(req_slot)];
      if (wr_en) begin
         bucket_mem[wr_addr] <= wr_data;
      end
   end

   // the read above sees old data when the item ahead writes the same slot
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      byp_addr_ff <= wr_addr;
      byp_data_ff <= wr_data;
   end

   // ---------------------------------------------------------------- compute stage
   assign slot_idx  = IDX_W'(req_slot_ff);
   assign slot_ok   = 32'(req_slot_ff) < 32'(NUM_BUCKETS);
   assign entry_cur = (byp_valid_ff && byp_addr_ff == slot_idx) ? byp_data_ff : bucket_rd_ff;

   tbt_alloc #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .IDX_W       (IDX_W)
   ) u_alloc (
      .used     (used_ff),
      .any_free (any_free),
      .free_idx (free_idx)
   );

   tbt_refill u_refill (
      .entry     (entry_cur),
      .now       (now_ff),
      .wanted    (req_wanted_ff),
      .entry_out (entry_fetched),
      .grant     (grant)
   );

   always_comb begin
      used_in       = used_ff;
      now_in        = now_ff;
      rsp_status_in = ST_OK;
      rsp_value_in  = 16'd0;
      wr_en         = 1'b0;
      wr_addr       = slot_idx;
      wr_data       = entry_fetched;
      if (req_valid_ff) begin
         case (req_cmd_ff)
            CMD_TICK: begin
               now_in = now_ff + 32'd1;
            end
            CMD_CREATE: begin
               if (req_rate_ff == 16'd0 || req_capacity_ff == 16'd0) begin
                  rsp_status_in = ST_BAD_ARG;
               end else if (!any_free) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  // new bucket starts full, stamped now
                  used_in[free_idx] = 1'b1;
                  wr_en             = 1'b1;
                  wr_addr           = free_idx;
                  wr_data.tokens    = req_capacity_ff;
                  wr_data.rate      = req_rate_ff;
                  wr_data.limit     = req_capacity_ff;
                  wr_data.stamp     = now_ff;
                  rsp_value_in      = 16'(free_idx);
               end
            end
            CMD_FETCH: begin
               // out-of-range slot or zero request is rejected before the slot's valid bit is looked at
               if (!slot_ok || req_wanted_ff == 16'd0) begin
                  rsp_status_in = ST_BAD_ARG;
               end else if (!used_ff[slot_idx]) begin
                  rsp_status_in = ST_NO_BUCKET;
               end else begin
                  wr_en        = 1'b1;
                  rsp_value_in = grant;
               end
            end
            CMD_DESTROY: begin
               if (!slot_ok) begin
                  rsp_status_in = ST_BAD_ARG;
               end else if (!used_ff[slot_idx]) begin
                  rsp_status_in = ST_NO_BUCKET;
               end else begin
                  used_in[slot_idx] = 1'b0;
               end
            end
            default: begin
               rsp_status_in = ST_BAD_ARG;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         now_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         now_ff       <= now_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

   // ---------------------------------------------------------------- checks
   `TBT_ASSERT_NEXT(a_result_follows, clock, reset, accept, ##1 rsp_valid)
   `TBT_ASSERT_NOW(a_error_zero_value, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == 16'd0)
   `TBT_ASSERT_NEXT(a_full_only_when_used, clock, reset, req_valid_ff && req_cmd_ff == CMD_CREATE && any_free, !(rsp_status == ST_FULL))
   `TBT_ASSERT_NEXT(a_grant_bounded, clock, reset, req_valid_ff && req_cmd_ff == CMD_FETCH, rsp_value <= $past(req_wanted_ff))

endmodule
